// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/sdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD SPI host package
// Widths, protocol constants and shared types of the SD card SPI-mode host.
// ----------------------------------------------------------------------------
package sdr_pkg;

  // Block geometry and counter widths.
  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned WAKE_BYTES  = 10;
  localparam int unsigned BLK_SHIFT   = $clog2(BLOCK_BYTES);
  localparam int unsigned BCNT_W      = $clog2(BLOCK_BYTES) + 1;
  localparam int unsigned WAIT_W      = 20;
  localparam int unsigned RLIM_W      = 8;
  localparam int unsigned FRAME_BYTES = 6;
  localparam int unsigned EXTRA_END   = 5;
  localparam int unsigned CRC_BYTES   = 2;

  // Input command codes.
  localparam logic [1:0] CMD_INIT = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_BYTE = 2'd2;

  // Completion status codes.
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NOT_IDLE     = 2'd1;
  localparam logic [1:0] ST_READ_REFUSED = 2'd2;
  localparam logic [1:0] ST_TOKEN_BAD    = 2'd3;

  // Configuration register indexes.
  localparam logic REG_REPLY_LIMIT = 1'b0;
  localparam logic REG_TOKEN_LIMIT = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [RLIM_W-1:0] RLIM_RESET = 8'd100;
  localparam logic [WAIT_W-1:0] TLIM_RESET = 20'd100000;

  // SD command indexes.
  localparam logic [5:0] SD_CMD0  = 6'd0;
  localparam logic [5:0] SD_CMD8  = 6'd8;
  localparam logic [5:0] SD_CMD17 = 6'd17;
  localparam logic [5:0] SD_CMD41 = 6'd41;
  localparam logic [5:0] SD_CMD55 = 6'd55;
  localparam logic [5:0] SD_CMD58 = 6'd58;

  // Bytes and arguments on the wire.
  localparam logic [1:0]  FRAME_START   = 2'b01;
  localparam logic [7:0]  IDLE_BYTE     = 8'hFF;
  localparam logic [7:0]  START_TOKEN   = 8'hFE;
  localparam logic [7:0]  CMD8_RETRY    = 8'h7F;
  localparam logic [7:0]  REPLY_IDLE    = 8'h01;
  localparam logic [7:0]  REPLY_ILLEGAL = 8'h05;
  localparam logic [7:0]  REPLY_READY   = 8'h00;
  localparam logic [7:0]  CRC_CMD0      = 8'h95;
  localparam logic [7:0]  CRC_CMD8      = 8'h87;
  localparam logic [7:0]  CRC_APP       = 8'h01;
  localparam logic [31:0] ARG_CMD8      = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS       = 32'h4000_0000;

  // Effective limits after a zero write is promoted to one.
  typedef struct packed {
    logic [RLIM_W-1:0] reply_lim;
    logic [WAIT_W-1:0] token_lim;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       chip_select;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       data_last;
    logic       done_res;
    logic [1:0] status;
    logic       high_capacity;
    logic       initialized;
  } res_t;

endpackage

// File: hdl/sdr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD SPI host input channel
// Valid/ready channel carrying one command or one received card byte per beat.
// ----------------------------------------------------------------------------
interface sdr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] sector;
  logic [7:0]  rx_byte;

  modport source (output valid, command, sector, rx_byte, input ready);
  modport sink (input valid, command, sector, rx_byte, output ready);
endinterface

// File: hdl/sdr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD SPI host output channel
// Valid/ready channel carrying the next SPI byte, block data and status.
// ----------------------------------------------------------------------------
interface sdr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_valid;
  logic       chip_select;
  logic [7:0] data_byte;
  logic       data_valid;
  logic       data_last;
  logic       done_res;
  logic [1:0] status;
  logic       high_capacity;
  logic       initialized;

  modport source (
    output valid, tx_byte, tx_valid, chip_select, data_byte, data_valid,
           data_last, done_res, status, high_capacity, initialized,
    input  ready
  );
  modport sink (
    input  valid, tx_byte, tx_valid, chip_select, data_byte, data_valid,
           data_last, done_res, status, high_capacity, initialized,
    output ready
  );
endinterface

// File: hdl/sdr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD SPI host configuration registers
// APB-style register file holding the reply poll and token wait limits.
// ----------------------------------------------------------------------------
module sdr_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output sdr_pkg::cfg_t       cfg_o
);

  logic [sdr_pkg::RLIM_W-1:0] reply_lim_q;
  logic [sdr_pkg::WAIT_W-1:0] token_lim_q;
  logic                       wr_en;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reply_lim_q <= sdr_pkg::RLIM_RESET;
      token_lim_q <= sdr_pkg::TLIM_RESET;
    end else if (wr_en) begin
      if (reg_sel == sdr_pkg::REG_REPLY_LIMIT) begin
        reply_lim_q <= pwdata[sdr_pkg::RLIM_W-1:0];
      end else begin
        token_lim_q <= pwdata[sdr_pkg::WAIT_W-1:0];
      end
    end
  end

  // Read back the stored values.
  always_comb begin
    if (reg_sel == sdr_pkg::REG_REPLY_LIMIT) begin
      prdata = {{(32 - sdr_pkg::RLIM_W){1'b0}}, reply_lim_q};
    end else begin
      prdata = {{(32 - sdr_pkg::WAIT_W){1'b0}}, token_lim_q};
    end
  end

  // A limit of zero behaves as a limit of one.
  always_comb begin
    cfg_o.reply_lim = (reply_lim_q == '0) ? sdr_pkg::RLIM_W'(1) : reply_lim_q;
    cfg_o.token_lim = (token_lim_q == '0) ? sdr_pkg::WAIT_W'(1) : token_lim_q;
  end

endmodule

// File: hdl/sdr_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD SPI host sequencer
// Card state and the per-byte decision logic for init and block read.
// ----------------------------------------------------------------------------
module sdr_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [1:0]          cmd_i,
  input  logic [31:0]         sector_i,
  input  logic [7:0]          rx_i,
  input  sdr_pkg::cfg_t       cfg_i,
  output sdr_pkg::res_t       res_o
);

  // Sequencer phases.
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_WAKE  = 4'd1;
  localparam logic [3:0] PH_FRAME = 4'd2;
  localparam logic [3:0] PH_POLL  = 4'd3;
  localparam logic [3:0] PH_EXTRA = 4'd4;
  localparam logic [3:0] PH_TAIL1 = 4'd5;
  localparam logic [3:0] PH_TAIL2 = 4'd6;
  localparam logic [3:0] PH_TOKEN = 4'd7;
  localparam logic [3:0] PH_DATA  = 4'd8;
  localparam logic [3:0] PH_CRC   = 4'd9;

  localparam int unsigned BW = sdr_pkg::BCNT_W;
  localparam int unsigned WW = sdr_pkg::WAIT_W;

  logic [3:0]    phase_q, phase_d;
  logic [5:0]    cur_q, cur_d;
  logic [31:0]   addr_q, addr_d;
  logic [BW-1:0] bcnt_q, bcnt_d;
  logic [WW-1:0] wait_q, wait_d;
  logic [7:0]    r0_q, r0_d;
  logic [7:0]    r1_q, r1_d;
  logic          v2_q, v2_d;
  logic          hc_q, hc_d;
  logic          init_q, init_d;
  logic          cs_q, cs_d;

  logic [BW-1:0] bcnt_inc;
  logic [WW-1:0] wait_inc;
  logic          reply_ok;
  logic          do_start;
  logic [5:0]    st_cmd;
  logic [31:0]   st_arg;
  logic          do_cfin;
  logic [7:0]    fin_r0;

  // Byte k of a six-byte command frame.
  function automatic logic [7:0] frame_byte(input logic [2:0] k, input logic [5:0] cmd,
                                            input logic [31:0] arg);
    logic [7:0] b;
    unique case (k)
      3'd0: b = {sdr_pkg::FRAME_START, cmd};
      3'd1: b = arg[31:24];
      3'd2: b = arg[23:16];
      3'd3: b = arg[15:8];
      3'd4: b = arg[7:0];
      default: begin
        if (cmd == sdr_pkg::SD_CMD0) begin
          b = sdr_pkg::CRC_CMD0;
        end else if (cmd == sdr_pkg::SD_CMD8) begin
          b = sdr_pkg::CRC_CMD8;
        end else if (cmd == sdr_pkg::SD_CMD55 || cmd == sdr_pkg::SD_CMD41) begin
          b = sdr_pkg::CRC_APP;
        end else begin
          b = sdr_pkg::IDLE_BYTE;
        end
      end
    endcase
    return b;
  endfunction

  assign bcnt_inc = bcnt_q + BW'(1);
  assign wait_inc = wait_q + WW'(1);

  // Next state and result for the item in the input register.
  always_comb begin
    phase_d  = phase_q;
    cur_d    = cur_q;
    addr_d   = addr_q;
    bcnt_d   = bcnt_q;
    wait_d   = wait_q;
    r0_d     = r0_q;
    r1_d     = r1_q;
    v2_d     = v2_q;
    hc_d     = hc_q;
    init_d   = init_q;
    cs_d     = cs_q;
    res_o    = '0;
    reply_ok = 1'b0;
    do_start = 1'b0;
    st_cmd   = sdr_pkg::SD_CMD0;
    st_arg   = '0;
    do_cfin  = 1'b0;
    fin_r0   = r0_q;

    unique case (cmd_i)
      sdr_pkg::CMD_INIT: begin
        init_d         = 1'b0;
        cs_d           = 1'b1;
        phase_d        = PH_WAKE;
        bcnt_d         = '0;
        res_o.tx_byte  = sdr_pkg::IDLE_BYTE;
        res_o.tx_valid = 1'b1;
      end
      sdr_pkg::CMD_READ: begin
        do_start = 1'b1;
        st_cmd   = sdr_pkg::SD_CMD17;
        st_arg   = hc_q ? sector_i : (sector_i << sdr_pkg::BLK_SHIFT);
      end
      sdr_pkg::CMD_BYTE: begin
        unique case (phase_q)
          PH_WAKE: begin
            bcnt_d = bcnt_inc;
            if (bcnt_inc >= BW'(sdr_pkg::WAKE_BYTES)) begin
              do_start = 1'b1;
              st_cmd   = sdr_pkg::SD_CMD0;
              st_arg   = '0;
            end else begin
              res_o.tx_byte  = sdr_pkg::IDLE_BYTE;
              res_o.tx_valid = 1'b1;
            end
          end
          PH_FRAME: begin
            bcnt_d = bcnt_inc;
            if (bcnt_inc < BW'(sdr_pkg::FRAME_BYTES)) begin
              res_o.tx_byte  = frame_byte(bcnt_inc[2:0], cur_q, addr_q);
              res_o.tx_valid = 1'b1;
            end else begin
              phase_d        = PH_POLL;
              wait_d         = '0;
              res_o.tx_byte  = sdr_pkg::IDLE_BYTE;
              res_o.tx_valid = 1'b1;
            end
          end
          PH_POLL: begin
            r0_d   = rx_i;
            wait_d = wait_inc;
            if (!rx_i[7]) begin
              if (cur_q == sdr_pkg::SD_CMD0 || cur_q == sdr_pkg::SD_CMD8 ||
                  cur_q == sdr_pkg::SD_CMD55) begin
                reply_ok = (rx_i == sdr_pkg::REPLY_IDLE) || (rx_i == sdr_pkg::REPLY_ILLEGAL);
              end else begin
                reply_ok = (rx_i == sdr_pkg::REPLY_READY);
              end
            end
            if (cur_q == sdr_pkg::SD_CMD8 && rx_i == sdr_pkg::CMD8_RETRY) begin
              // Card busy with CMD8: send the whole frame again.
              phase_d        = PH_FRAME;
              bcnt_d         = '0;
              res_o.tx_byte  = frame_byte(3'd0, cur_q, addr_q);
              res_o.tx_valid = 1'b1;
            end else if (reply_ok || wait_inc >= WW'(cfg_i.reply_lim)) begin
              if (cur_q == sdr_pkg::SD_CMD8 || cur_q == sdr_pkg::SD_CMD58) begin
                phase_d        = PH_EXTRA;
                bcnt_d         = BW'(1);
                res_o.tx_byte  = sdr_pkg::IDLE_BYTE;
                res_o.tx_valid = 1'b1;
              end else if (cur_q == sdr_pkg::SD_CMD17) begin
                do_cfin = 1'b1;
                fin_r0  = rx_i;
              end else begin
                phase_d        = PH_TAIL1;
                res_o.tx_byte  = sdr_pkg::IDLE_BYTE;
                res_o.tx_valid = 1'b1;
              end
            end else begin
              res_o.tx_byte  = sdr_pkg::IDLE_BYTE;
              res_o.tx_valid = 1'b1;
            end
          end
          PH_EXTRA: begin
            // Only the first OCR byte is ever looked at.
            if (bcnt_q == BW'(1)) begin
              r1_d = rx_i;
            end
            bcnt_d = bcnt_inc;
            if (bcnt_inc >= BW'(sdr_pkg::EXTRA_END)) begin
              if (cur_q == sdr_pkg::SD_CMD58) begin
                hc_d = r1_q[6];
              end
              phase_d = PH_TAIL1;
            end
            res_o.tx_byte  = sdr_pkg::IDLE_BYTE;
            res_o.tx_valid = 1'b1;
          end
          PH_TAIL1: begin
            cs_d           = 1'b1;
            phase_d        = PH_TAIL2;
            res_o.tx_byte  = sdr_pkg::IDLE_BYTE;
            res_o.tx_valid = 1'b1;
          end
          PH_TAIL2: begin
            do_cfin = 1'b1;
          end
          PH_TOKEN: begin
            wait_d = wait_inc;
            if (rx_i != sdr_pkg::IDLE_BYTE) begin
              if (rx_i == sdr_pkg::START_TOKEN) begin
                phase_d        = PH_DATA;
                bcnt_d         = '0;
                res_o.tx_byte  = sdr_pkg::IDLE_BYTE;
                res_o.tx_valid = 1'b1;
              end else begin
                phase_d        = PH_IDLE;
                res_o.done_res = 1'b1;
                res_o.status   = sdr_pkg::ST_TOKEN_BAD;
              end
            end else if (wait_inc >= cfg_i.token_lim) begin
              phase_d        = PH_IDLE;
              res_o.done_res = 1'b1;
              res_o.status   = sdr_pkg::ST_TOKEN_BAD;
            end else begin
              res_o.tx_byte  = sdr_pkg::IDLE_BYTE;
              res_o.tx_valid = 1'b1;
            end
          end
          PH_DATA: begin
            res_o.data_byte  = rx_i;
            res_o.data_valid = 1'b1;
            bcnt_d           = bcnt_inc;
            if (bcnt_inc >= BW'(sdr_pkg::BLOCK_BYTES)) begin
              res_o.data_last = 1'b1;
              phase_d         = PH_CRC;
              bcnt_d          = '0;
            end
            res_o.tx_byte  = sdr_pkg::IDLE_BYTE;
            res_o.tx_valid = 1'b1;
          end
          PH_CRC: begin
            bcnt_d = bcnt_inc;
            if (bcnt_inc >= BW'(sdr_pkg::CRC_BYTES)) begin
              cs_d           = 1'b1;
              phase_d        = PH_IDLE;
              res_o.done_res = 1'b1;
              res_o.status   = sdr_pkg::ST_OK;
            end else begin
              res_o.tx_byte  = sdr_pkg::IDLE_BYTE;
              res_o.tx_valid = 1'b1;
            end
          end
          default: begin
            // Idle: a stray card byte changes nothing.
          end
        endcase
      end
      default: begin
        // Unused command code: ignored.
      end
    endcase

    // A command has run to completion: start the next one, wait for the start token, or end the operation.
    if (do_cfin) begin
      unique case (cur_q)
        sdr_pkg::SD_CMD0: begin
          if (fin_r0 != sdr_pkg::REPLY_IDLE) begin
            phase_d        = PH_IDLE;
            res_o.done_res = 1'b1;
            res_o.status   = sdr_pkg::ST_NOT_IDLE;
          end else begin
            do_start = 1'b1;
            st_cmd   = sdr_pkg::SD_CMD8;
            st_arg   = sdr_pkg::ARG_CMD8;
          end
        end
        sdr_pkg::SD_CMD8: begin
          v2_d     = (fin_r0 == sdr_pkg::REPLY_IDLE);
          do_start = 1'b1;
          st_cmd   = sdr_pkg::SD_CMD55;
        end
        sdr_pkg::SD_CMD55: begin
          do_start = 1'b1;
          st_cmd   = sdr_pkg::SD_CMD41;
          st_arg   = v2_q ? sdr_pkg::ARG_HCS : '0;
        end
        sdr_pkg::SD_CMD41: begin
          do_start = 1'b1;
          st_cmd   = (fin_r0 == sdr_pkg::REPLY_READY) ? sdr_pkg::SD_CMD58 : sdr_pkg::SD_CMD55;
        end
        sdr_pkg::SD_CMD58: begin
          init_d         = 1'b1;
          phase_d        = PH_IDLE;
          res_o.done_res = 1'b1;
          res_o.status   = sdr_pkg::ST_OK;
        end
        default: begin
          // Block read: the reply gates the wait for the start token.
          if (fin_r0 != sdr_pkg::REPLY_READY) begin
            phase_d        = PH_IDLE;
            res_o.done_res = 1'b1;
            res_o.status   = sdr_pkg::ST_READ_REFUSED;
          end else begin
            phase_d        = PH_TOKEN;
            wait_d         = '0;
            res_o.tx_byte  = sdr_pkg::IDLE_BYTE;
            res_o.tx_valid = 1'b1;
          end
        end
      endcase
    end

    // Launch a new command frame with the card selected.
    if (do_start) begin
      cur_d          = st_cmd;
      addr_d         = st_arg;
      r0_d           = '0;
      r1_d           = '0;
      cs_d           = 1'b0;
      phase_d        = PH_FRAME;
      bcnt_d         = '0;
      res_o.tx_byte  = frame_byte(3'd0, st_cmd, st_arg);
      res_o.tx_valid = 1'b1;
    end

    res_o.chip_select   = cs_d;
    res_o.high_capacity = hc_d;
    res_o.initialized   = init_d;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cur_q   <= '0;
      addr_q  <= '0;
      bcnt_q  <= '0;
      wait_q  <= '0;
      r0_q    <= '0;
      r1_q    <= '0;
      v2_q    <= 1'b0;
      hc_q    <= 1'b0;
      init_q  <= 1'b0;
      cs_q    <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      cur_q   <= cur_d;
      addr_q  <= addr_d;
      bcnt_q  <= bcnt_d;
      wait_q  <= wait_d;
      r0_q    <= r0_d;
      r1_q    <= r1_d;
      v2_q    <= v2_d;
      hc_q    <= hc_d;
      init_q  <= init_d;
      cs_q    <= cs_d;
    end
  end

endmodule

// File: hdl/sd_spi_init_and_block_read.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD card SPI-mode host: initialization and single block read
// Byte-exchange sequencer with an input register and a result register.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one beat per SPI byte exchange: command 0 starts card
//   initialization, command 1 starts a block read of the given sector, and
//   command 2 hands back the byte the card returned in the last exchange.
//   out_o returns exactly one beat per input beat: the next byte to shift
//   out and its select level, block data with a last flag, and the done
//   flag with a status code when an operation ends.
//   The APB port sets the reply poll limit (offset 0) and the start token
//   wait limit (offset 4); write them only while no operation is running.
// Timing:
//   An input beat is registered in the input register and decided when it moves on
//   to the result register, which offers its result beat on out_o.
//   While out_o is not stalled, one beat is accepted per cycle; the sequencer
//   state updates in the same cycle as the result register, which sets that rate.
// Reset and stall:
//   Reset empties both registers, deselects the card and clears all state.
//   When out_o is stalled the result holds and one more input beat can wait
//   in the input register before in_i.ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sd_spi_init_and_block_read (
  input  logic        clk_i,
  input  logic        rst_ni,
  sdr_in_if.sink      in_i,
  sdr_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sdr_pkg::cfg_t cfg;
  sdr_pkg::res_t res_d, res_q;

  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  cmd_q;
  logic [31:0] sector_q;
  logic [7:0]  rx_q;
  logic        out_valid_q, out_valid_d;
  logic        adv;
  logic        in_acc;

  // Configuration registers.
  sdr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline handshake: the input stage moves when the result slot frees.
  assign adv         = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || adv;
  assign in_acc      = in_i.valid && in_i.ready;
  assign s1_valid_d  = in_acc || (s1_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q    <= in_i.command;
      sector_q <= in_i.sector;
      rx_q     <= in_i.rx_byte;
    end
  end

  // Sequencer decides the result and updates its state on advance.
  sdr_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .cmd_i    (cmd_q),
    .sector_i (sector_q),
    .rx_i     (rx_q),
    .cfg_i    (cfg),
    .res_o    (res_d)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.tx_byte       = res_q.tx_byte;
  assign out_o.tx_valid      = res_q.tx_valid;
  assign out_o.chip_select   = res_q.chip_select;
  assign out_o.data_byte     = res_q.data_byte;
  assign out_o.data_valid    = res_q.data_valid;
  assign out_o.data_last     = res_q.data_last;
  assign out_o.done_res      = res_q.done_res;
  assign out_o.status        = res_q.status;
  assign out_o.high_capacity = res_q.high_capacity;
  assign out_o.initialized   = res_q.initialized;

  // Checks on the sequencer and the pipeline.
  `ASSERT_IMPLY(a_status_on_done, clk_i, rst_ni, out_valid_q && res_q.status != sdr_pkg::ST_OK, res_q.done_res)
  `ASSERT_IMPLY(a_done_stops_tx, clk_i, rst_ni, out_valid_q && res_q.done_res, !res_q.tx_valid)
  `ASSERT_IMPLY(a_data_selected, clk_i, rst_ni, out_valid_q && res_q.data_valid, res_q.tx_valid && !res_q.chip_select)
  `ASSERT_IMPLY(a_last_is_data, clk_i, rst_ni, out_valid_q && res_q.data_last, res_q.data_valid)
  `ASSERT_NEXT(a_adv_fills_out, clk_i, rst_ni, adv, out_valid_q)

endmodule
